[sv/isml_pkg.sv]
// Shared types and constants for the indexed store minimum index lookup.
package isml_pkg;

   // Fixed field widths of the request and response channels.
   localparam int SLOT_W      = 10;
   localparam int NUM_W       = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   // Defaults for the top-level parameters.
   localparam int DEF_SLOT_COUNT  = 1024;
   localparam int DEF_VALUE_WIDTH = 32;

   // Request kinds carried in req_tuser.
   localparam logic OP_CHANGE = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   // Slot reported when no slot holds the searched number.
   localparam logic [SLOT_W-1:0] NOT_FOUND_SLOT = '0;

   // Request token that walks down the cell chain, one cell per cycle unless the chain stalls.
   typedef struct packed {
      logic              vld;
      logic              op;
      logic [SLOT_W-1:0] idx;
      logic              found;
      logic [SLOT_W-1:0] first;
   } tok_type;

endpackage

[sv/indexed_store_min_index_lookup.sv]
// Top level of the slot table with smallest-index match, built as a chain of slot cells.
//
//   channel  | direction | tdata (low bits first)          | tuser
//   ---------+-----------+---------------------------------+----------------
//   req_     | in        | slot_index[9:0], number[41:10]  | operation[0]
//   rsp_     | out       | first_slot[9:0], zero fill      | found[0]
//
// Unless the chain stalls, each request enters cell 0 and moves one cell per cycle, and one can enter every cycle.
// A find's response is registered in the response register once its token leaves the last
// cell; a change gives none.
// Latency is set by the length of the cell chain, one register stage per slot.
// Reset empties every slot at once and clears all tokens in flight.
// The chain stalls only while a find sits in the last cell and the response register holds
// a response that is not being taken.
module indexed_store_min_index_lookup
   import isml_pkg::*;
#(
   parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // slot_index[9:0], number[41:10], zero fill
   input  logic [0:0]             req_tuser,  // operation[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // first_slot[9:0], zero fill
   output logic [0:0]             rsp_tuser   // found[0]
);

   tok_type                tok [0:SLOT_COUNT];
   logic [VALUE_WIDTH-1:0] key [0:SLOT_COUNT];
   logic                   advance;
   tok_type                tail;
   logic                   tail_find;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_found_ff;
   logic [SLOT_W-1:0]      rsp_first_ff;

   // Unpack the request into the token at the head of the chain.
   assign tok[0].vld   = req_tvalid;
   assign tok[0].op    = req_tuser[0];
   assign tok[0].idx   = req_tdata[SLOT_W-1:0];
   assign tok[0].found = 1'b0;
   assign tok[0].first = NOT_FOUND_SLOT;
   assign key[0]       = VALUE_WIDTH'(req_tdata[SLOT_W+NUM_W-1:SLOT_W]);

   // Row of slot cells, lowest slot first so the earliest hit wins.
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      isml_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_tok  (tok[i]),
         .up_key  (key[i]),
         .dn_tok  (tok[i+1]),
         .dn_key  (key[i+1])
      );
   end

   // Stall the chain only when a find result has nowhere to go.
   assign tail      = tok[SLOT_COUNT];
   assign tail_find = tail.vld && (tail.op == OP_FIND);
   assign advance   = !(tail_find && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance;

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && tail_find) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail_find) begin
         rsp_found_ff <= tail.found;
         rsp_first_ff <= tail.found ? tail.first : NOT_FOUND_SLOT;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-SLOT_W){1'b0}}, rsp_first_ff};

endmodule

[sv/isml_cell.sv]
// One slot of the table: stores a value and matches the passing request token.
module isml_cell
   import isml_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int CELL_INDEX  = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tok_type                up_tok,
   input  logic [VALUE_WIDTH-1:0] up_key,
   output tok_type                dn_tok,
   output logic [VALUE_WIDTH-1:0] dn_key
);

   // Cells past the reach of the slot index field can never be written.
   localparam bit                WRITABLE = CELL_INDEX < (1 << SLOT_W);
   localparam logic [SLOT_W-1:0] CELL_ID  = SLOT_W'(CELL_INDEX);

   logic                   valid_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   tok_type                tok_ff;
   tok_type                tok_in;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic                   write_en;
   logic                   hit;

   // A change request addressed to this slot writes it as it passes.
   assign write_en = advance && up_tok.vld && (up_tok.op == OP_CHANGE) &&
                     WRITABLE && (up_tok.idx == CELL_ID);

   // The first filled slot that holds the key claims a find request.
   assign hit = up_tok.vld && (up_tok.op == OP_FIND) && !up_tok.found &&
                valid_ff && (value_ff == up_key);

   always_comb begin
      tok_in = up_tok;
      if (hit) begin
         tok_in.found = 1'b1;
         tok_in.first = CELL_ID;
      end
   end

   // Slot contents; the valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (write_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         value_ff <= up_key;
      end
   end

   // Hand the token and its key on to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff <= up_key;
      end
   end

   assign dn_tok = tok_ff;
   assign dn_key = key_ff;

endmodule

[sv/isml_checker.sv]
// Port-level checks for the slot table lookup, bound to the top level.
module isml_checker
   import isml_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [0:0]             req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]             rsp_tuser
);

   // No response is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Requests are refused only while a response is stuck at the output.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request refused without output back-pressure");

   // A miss reports the not-found slot.
   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[SLOT_W-1:0] == NOT_FOUND_SLOT))
      else $error("miss with nonzero slot");

   // Fill bits above the slot field stay zero.
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:SLOT_W] == '0))
      else $error("response fill bits not zero");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind indexed_store_min_index_lookup isml_checker u_isml_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/tb.sv]
// Self-checking testbench for the slot table with smallest-index match.
`timescale 1ns / 100ps

module tb;
   import isml_pkg::*;

   localparam int SLOT_COUNT     = DEF_SLOT_COUNT;
   localparam int VALUE_WIDTH    = DEF_VALUE_WIDTH;
   localparam int FIND_LATENCY   = SLOT_COUNT + 1;
   localparam int HOLD_CYCLES    = 1600;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 10;
   localparam int DIRECTED_ROWS  = 22;

   // One expected find outcome.
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } match_type;

   // One row of the directed table; known marks a hand-written expectation.
   typedef struct packed {
      logic              op;
      logic [SLOT_W-1:0] idx;
      logic [NUM_W-1:0]  num;
      logic              known;
      match_type         want;
   } stim_row_type;

   localparam match_type MISS = '{1'b0, NOT_FOUND_SLOT};

   // Directed stimulus: extremes, zero as a stored number, replacement and misses.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_FIND,   10'd0,    32'h0000_0000, 1'b1, MISS},
      '{OP_FIND,   10'd1023, 32'hFFFF_FFFF, 1'b1, MISS},
      '{OP_CHANGE, 10'd1023, 32'hFFFF_FFFF, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd1023}},
      '{OP_CHANGE, 10'd0,    32'h0000_0000, 1'b0, MISS},
      '{OP_FIND,   10'd5,    32'h0000_0000, 1'b1, '{1'b1, 10'd0}},
      '{OP_CHANGE, 10'd5,    32'hFFFF_FFFF, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'hFFFF_FFFF, 1'b0, MISS},
      '{OP_CHANGE, 10'd5,    32'h0000_007B, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'hFFFF_FFFF, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'h0000_007B, 1'b0, MISS},
      '{OP_CHANGE, 10'd0,    32'h0000_0007, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'h0000_0000, 1'b0, MISS},
      '{OP_CHANGE, 10'd512,  32'h8000_0000, 1'b0, MISS},
      '{OP_FIND,   10'd1023, 32'h8000_0000, 1'b0, MISS},
      '{OP_CHANGE, 10'd3,    32'h5555_5555, 1'b0, MISS},
      '{OP_CHANGE, 10'd2,    32'hAAAA_AAAA, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'h5555_5555, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'hAAAA_AAAA, 1'b0, MISS},
      '{OP_CHANGE, 10'd1,    32'h8000_0000, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'h8000_0000, 1'b0, MISS},
      '{OP_FIND,   10'd0,    32'h1234_5678, 1'b0, MISS}
   };

   // Numbers that recur often so that random finds hit filled slots.
   localparam logic [NUM_W-1:0] NUMBER_POOL [16] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF,
      32'h0000_00FF, 32'hFF00_0000, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h0001_0000, 32'h1234_5678, 32'hCAFE_F00D, 32'h0F0F_0F0F
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // slot_index[9:0], number[41:10], zero fill
   logic [0:0]             req_tuser  = '0;  // operation[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // first_slot[9:0], zero fill
   logic [0:0]             rsp_tuser;        // found[0]

   // Shadow of the slot table, updated in request order.
   logic             slot_filled [SLOT_COUNT];
   logic [NUM_W-1:0] slot_number [SLOT_COUNT];

   // Find outcomes still waiting for their response.
   match_type pending_matches[$];

   int  send_idle_pct  = 0;
   int  rsp_stall_pct  = 0;
   bit  hold_start     = 1'b0;
   int  idle_cycles    = 0;
   int  n_errors       = 0;
   int  n_changes      = 0;
   int  n_finds        = 0;
   int  n_hits         = 0;
   int  n_checked      = 0;
   int  n_input_stalls = 0;

   indexed_store_min_index_lookup #(
      .SLOT_COUNT  (SLOT_COUNT),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 12 ns period.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Smallest filled slot holding the number, or a miss.
   function automatic match_type lookup_first_slot(input logic [NUM_W-1:0] num);
      match_type m;
      m = MISS;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_filled[i] && slot_number[i] == num) begin
            m.found = 1'b1;
            m.slot  = SLOT_W'(i);
         end
      end
      return m;
   endfunction

   // Update the shadow table or queue the expected find outcome for an accepted request.
   task automatic record_request(input logic op, input logic [SLOT_W-1:0] idx,
                                 input logic [NUM_W-1:0] num, input logic known,
                                 input match_type want);
      match_type m;
      if (op == OP_CHANGE) begin
         n_changes++;
         // A slot index beyond the table leaves it unchanged.
         if (int'(idx) < SLOT_COUNT) begin
            slot_filled[idx] = 1'b1;
            slot_number[idx] = num;
         end
      end else begin
         n_finds++;
         m = known ? want : lookup_first_slot(num);
         if (m.found) n_hits++;
         pending_matches.push_back(m);
      end
   endtask

   // Offer one request, with random idle cycles before it, and wait until it is taken.
   task automatic issue_request(input logic op, input logic [SLOT_W-1:0] idx,
                                input logic [NUM_W-1:0] num, input logic known,
                                input match_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W - SLOT_W - NUM_W){1'b0}}, num, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      record_request(op, idx, num, known, want);
   endtask

   // Random requests: mostly low slots and recurring numbers, so finds hit and slots get replaced.
   task automatic issue_random_batch(input int count);
      logic              op;
      logic [SLOT_W-1:0] idx;
      logic [NUM_W-1:0]  num;
      int                pick;
      for (int k = 0; k < count; k++) begin
         op   = ($urandom_range(99) < 45) ? OP_FIND : OP_CHANGE;
         pick = $urandom_range(99);
         if (pick < 55)      idx = SLOT_W'($urandom_range(31));
         else if (pick < 65) idx = SLOT_W'($urandom_range(1023, 992));
         else                idx = SLOT_W'($urandom_range(1023));
         if ($urandom_range(3) == 0) num = $urandom;
         else                        num = NUMBER_POOL[$urandom_range(15)];
         issue_request(op, idx, num, 1'b0, MISS);
      end
   endtask

   // Hold the sender until every expected response has come back.
   task automatic drain_matches;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_matches.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off counted here.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each accepted response with the oldest expected find outcome.
   always @(posedge clock) begin
      match_type m;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $display("ERROR: response with nothing expected: found=%0d slot=%0d",
                        rsp_tuser[0], rsp_tdata[SLOT_W-1:0]);
         end else begin
            m = pending_matches.pop_front();
            n_checked++;
            if (rsp_tuser[0] !== m.found || rsp_tdata[SLOT_W-1:0] !== m.slot) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("ERROR: response %0d: expected found=%0d slot=%0d, got found=%0d slot=%0d",
                           n_checked, m.found, m.slot, rsp_tuser[0], rsp_tdata[SLOT_W-1:0]);
            end
         end
      end
      if (!reset && req_tvalid && !req_tready) n_input_stalls++;
   end

   // Watchdog: ends the run when no request moves on either side for too long.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else                                                          idle_cycles++;
      end
      $display("ERROR: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Main sequence: reset, directed table, random phases, pressure, final check.
   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_filled[i] = 1'b0;
         slot_number[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no idling.
      for (int r = 0; r < DIRECTED_ROWS; r++)
         issue_request(DIRECTED[r].op, DIRECTED[r].idx, DIRECTED[r].num,
                       DIRECTED[r].known, DIRECTED[r].want);

      // Random phases with different idling on each side.
      issue_random_batch(150);
      send_idle_pct = 57;
      issue_random_batch(150);
      send_idle_pct = 0;
      rsp_stall_pct = 57;
      issue_random_batch(150);
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      issue_random_batch(150);

      // Sender pauses until every find has been answered.
      drain_matches;

      // Long receiver hold-off while the sender keeps going at full rate.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_start    = 1'b1;
      issue_random_batch(1200);

      // Final stretch with no idling, then drain and let the chain empty.
      issue_random_batch(100);
      drain_matches;
      repeat (FIND_LATENCY + 16) @(posedge clock);

      $display("Covered %0d changes and %0d finds (%0d hits), %0d responses checked.",
               n_changes, n_finds, n_hits, n_checked);
      $display("Input was held back for %0d cycles while the response side was stalled.",
               n_input_stalls);
      if (n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches in total", n_errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
sv/isml_pkg.sv
sv/isml_cell.sv
sv/indexed_store_min_index_lookup.sv
sv/isml_checker.sv
dv/tb.sv
